@@ sv/tse_pkg.sv @@
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants of the TLS server-name extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package tse_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  VER_MAJOR_3     = 8'h03;
  localparam logic [7:0]  VER_MAJOR_2     = 8'h02;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam logic [7:0]  EXT_TYPE_SNI_HI = 8'h00;
  localparam logic [7:0]  EXT_TYPE_SNI_LO = 8'h00;
  localparam logic [16:0] POS_HDR_TYPE    = 17'd0;
  localparam logic [16:0] POS_HDR_VER     = 17'd1;
  localparam logic [16:0] POS_HS_TYPE     = 17'd5;
  localparam logic [16:0] POS_MAX         = 17'h1FFFF;
  localparam logic [17:0] RANDOM_LEN      = 18'd32;
  localparam logic [17:0] SID_OFFSET      = 18'd11 + RANDOM_LEN;
  localparam logic [15:0] SNI_MIN_EXT_LEN = 16'd5;
  localparam logic [17:0] SNI_LIST_HDR    = 18'd3;
  localparam logic [17:0] EXT_HDR_LEN     = 18'd4;

  typedef enum logic [15:0] {
    PH_IDLE    = 16'h0001,
    PH_HDR     = 16'h0002,
    PH_SID     = 16'h0004,
    PH_CS_HI   = 16'h0008,
    PH_CS_LO   = 16'h0010,
    PH_COMP    = 16'h0020,
    PH_EXT_HI  = 16'h0040,
    PH_EXT_LO  = 16'h0080,
    PH_TYPE_HI = 16'h0100,
    PH_TYPE_LO = 16'h0200,
    PH_ELEN_HI = 16'h0400,
    PH_ELEN_LO = 16'h0800,
    PH_NLEN_HI = 16'h1000,
    PH_NLEN_LO = 16'h2000,
    PH_NAME    = 16'h4000,
    PH_DONE    = 16'h8000
  } phase_t;

  typedef struct packed {
    logic        has_name;
    logic [7:0]  name_byte;
    logic        has_verdict;
    logic        found;
    logic [15:0] length;
  } entry_t;

endpackage

`default_nettype wire

@@ sv/tse_parser.sv @@
// ----------------------------------------------------------------------------
// tse_parser
// Input register and ClientHello walk; yields at most one queue entry per payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            take,
  input  wire logic [7:0]      payload_byte,
  input  wire logic [15:0]     payload_length,
  input  wire logic            first_byte,
  input  wire logic            final_byte,
  output logic                 busy,
  output logic                 push,
  output tse_pkg::entry_t      entry
);

  logic                   in_vld_r;
  logic [7:0]             in_byte_r;
  logic [15:0]            in_len_r;
  logic                   in_first_r;
  logic                   in_final_r;

  tse_pkg::phase_t        phase_r, phase_nxt, ph_c;
  logic [16:0]            pos_r, pos_nxt, pos_c;
  logic [17:0]            nfo_r, nfo_nxt, nfo_c;
  logic [17:0]            eend_r, eend_nxt, eend_c;
  logic [7:0]             hold_r, hold_nxt, hold_c;
  logic [15:0]            elen_r, elen_nxt, elen_c;
  logic [15:0]            nrem_r, nrem_nxt, nrem_c;
  logic [15:0]            flen_r, flen_nxt, flen_c;

  logic [17:0]            pos_ext;
  logic [17:0]            body;
  logic [15:0]            v16;
  logic [17:0]            byte_off;
  logic [17:0]            word_off;
  logic [15:0]            elen_new;
  logic                   ext_fit;
  logic [17:0]            skip_off;
  logic                   name_fit;
  logic [17:0]            back_off;
  logic [15:0]            nrem_dec;
  logic                   emit;

  function automatic tse_pkg::phase_t to_header(logic [17:0] nfo, logic [17:0] eend);
    if (({1'b0, nfo} + {1'b0, tse_pkg::EXT_HDR_LEN}) <= {1'b0, eend}) begin
      return tse_pkg::PH_TYPE_HI;
    end
    return tse_pkg::PH_DONE;
  endfunction

  assign busy = in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte_r  <= payload_byte;
      in_len_r   <= payload_length;
      in_first_r <= first_byte;
      in_final_r <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tse_pkg::PH_IDLE;
      pos_r   <= '0;
      nfo_r   <= '0;
      eend_r  <= '0;
      hold_r  <= '0;
      elen_r  <= '0;
      nrem_r  <= '0;
      flen_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      nfo_r   <= nfo_nxt;
      eend_r  <= eend_nxt;
      hold_r  <= hold_nxt;
      elen_r  <= elen_nxt;
      nrem_r  <= nrem_nxt;
      flen_r  <= flen_nxt;
    end
  end

  always_comb begin
    ph_c   = in_first_r ? tse_pkg::PH_HDR : phase_r;
    pos_c  = in_first_r ? '0 : pos_r;
    nfo_c  = in_first_r ? '0 : nfo_r;
    eend_c = in_first_r ? '0 : eend_r;
    hold_c = in_first_r ? '0 : hold_r;
    elen_c = in_first_r ? '0 : elen_r;
    nrem_c = in_first_r ? '0 : nrem_r;
    flen_c = in_first_r ? '0 : flen_r;
  end

  assign pos_ext  = {1'b0, pos_c};
  assign body     = pos_ext + 18'd1;
  assign v16      = {hold_c, in_byte_r};
  assign byte_off = body + {10'd0, in_byte_r};
  assign word_off = body + {2'd0, v16};
  assign elen_new = {elen_c[15:8], in_byte_r};
  assign ext_fit  = ({1'b0, body} + {3'd0, elen_new}) <= {3'd0, in_len_r};
  assign skip_off = body + {2'd0, elen_new};
  assign name_fit = ((elen_c < tse_pkg::SNI_MIN_EXT_LEN) ||
                     (v16 <= (elen_c - tse_pkg::SNI_MIN_EXT_LEN))) &&
                    (({1'b0, word_off}) <= {3'd0, in_len_r});
  assign back_off = pos_ext - tse_pkg::EXT_HDR_LEN + {2'd0, elen_c};
  assign nrem_dec = nrem_c - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    nfo_nxt   = nfo_r;
    eend_nxt  = eend_r;
    hold_nxt  = hold_r;
    elen_nxt  = elen_r;
    nrem_nxt  = nrem_r;
    flen_nxt  = flen_r;
    emit      = 1'b0;
    entry     = '0;
    push      = 1'b0;
    if (in_vld_r) begin
      phase_nxt = ph_c;
      pos_nxt   = pos_c;
      nfo_nxt   = nfo_c;
      eend_nxt  = eend_c;
      hold_nxt  = hold_c;
      elen_nxt  = elen_c;
      nrem_nxt  = nrem_c;
      flen_nxt  = flen_c;
      if (ph_c != tse_pkg::PH_IDLE) begin
        if (pos_c < {1'b0, in_len_r}) begin
          unique case (ph_c)
            tse_pkg::PH_HDR: begin
              if ((pos_c == tse_pkg::POS_HDR_TYPE && in_byte_r != tse_pkg::REC_HANDSHAKE) ||
                  (pos_c == tse_pkg::POS_HDR_VER && in_byte_r != tse_pkg::VER_MAJOR_3 &&
                   in_byte_r != tse_pkg::VER_MAJOR_2) ||
                  (pos_c == tse_pkg::POS_HS_TYPE &&
                   in_byte_r != tse_pkg::HS_CLIENT_HELLO)) begin
                phase_nxt = tse_pkg::PH_DONE;
              end else if (pos_c == tse_pkg::POS_HS_TYPE) begin
                nfo_nxt   = tse_pkg::SID_OFFSET;
                phase_nxt = tse_pkg::PH_SID;
              end
            end
            tse_pkg::PH_SID: begin
              if (pos_ext == nfo_c) begin
                nfo_nxt   = byte_off;
                phase_nxt = tse_pkg::PH_CS_HI;
              end
            end
            tse_pkg::PH_CS_HI: begin
              if (pos_ext == nfo_c) begin
                hold_nxt  = in_byte_r;
                phase_nxt = tse_pkg::PH_CS_LO;
              end
            end
            tse_pkg::PH_CS_LO: begin
              nfo_nxt   = word_off;
              phase_nxt = tse_pkg::PH_COMP;
            end
            tse_pkg::PH_COMP: begin
              if (pos_ext == nfo_c) begin
                nfo_nxt   = byte_off;
                phase_nxt = tse_pkg::PH_EXT_HI;
              end
            end
            tse_pkg::PH_EXT_HI: begin
              if (pos_ext == nfo_c) begin
                hold_nxt  = in_byte_r;
                phase_nxt = tse_pkg::PH_EXT_LO;
              end
            end
            tse_pkg::PH_EXT_LO: begin
              eend_nxt  = word_off;
              nfo_nxt   = body;
              phase_nxt = to_header(body, word_off);
            end
            tse_pkg::PH_TYPE_HI: begin
              if (pos_ext == nfo_c) begin
                hold_nxt  = in_byte_r;
                phase_nxt = tse_pkg::PH_TYPE_LO;
              end
            end
            tse_pkg::PH_TYPE_LO: begin
              hold_nxt  = (hold_c == tse_pkg::EXT_TYPE_SNI_HI &&
                           in_byte_r == tse_pkg::EXT_TYPE_SNI_LO) ? 8'd1 : 8'd0;
              phase_nxt = tse_pkg::PH_ELEN_HI;
            end
            tse_pkg::PH_ELEN_HI: begin
              elen_nxt  = {in_byte_r, 8'd0};
              phase_nxt = tse_pkg::PH_ELEN_LO;
            end
            tse_pkg::PH_ELEN_LO: begin
              elen_nxt = elen_new;
              if (hold_c == 8'd1 && ext_fit && elen_new >= tse_pkg::SNI_MIN_EXT_LEN) begin
                nfo_nxt   = body + tse_pkg::SNI_LIST_HDR;
                phase_nxt = tse_pkg::PH_NLEN_HI;
              end else begin
                nfo_nxt   = skip_off;
                phase_nxt = to_header(skip_off, eend_c);
              end
            end
            tse_pkg::PH_NLEN_HI: begin
              if (pos_ext == nfo_c) begin
                hold_nxt  = in_byte_r;
                phase_nxt = tse_pkg::PH_NLEN_LO;
              end
            end
            tse_pkg::PH_NLEN_LO: begin
              if (name_fit) begin
                if (v16 == 16'd0) begin
                  phase_nxt = tse_pkg::PH_DONE;
                end else begin
                  elen_nxt  = v16;
                  nrem_nxt  = v16;
                  phase_nxt = tse_pkg::PH_NAME;
                end
              end else begin
                nfo_nxt   = back_off;
                phase_nxt = to_header(back_off, eend_c);
              end
            end
            tse_pkg::PH_NAME: begin
              emit     = 1'b1;
              nrem_nxt = nrem_dec;
              if (nrem_dec == 16'd0) begin
                flen_nxt  = elen_c;
                phase_nxt = tse_pkg::PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
        if (pos_c != tse_pkg::POS_MAX) begin
          pos_nxt = pos_c + 17'd1;
        end
      end
      entry.has_name    = emit;
      entry.name_byte   = in_byte_r;
      entry.has_verdict = in_final_r;
      entry.found       = (flen_nxt != 16'd0);
      entry.length      = flen_nxt;
      push              = emit || in_final_r;
      if (in_final_r) begin
        phase_nxt = tse_pkg::PH_IDLE;
        pos_nxt   = '0;
        nfo_nxt   = '0;
        eend_nxt  = '0;
        hold_nxt  = '0;
        elen_nxt  = '0;
        nrem_nxt  = '0;
        flen_nxt  = '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/tse_out_queue.sv @@
// ----------------------------------------------------------------------------
// tse_out_queue
// Result queue; splits an entry into its name-byte and verdict items.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_out_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire tse_pkg::entry_t               entry,
  output logic [tse_pkg::QCNT_W-1:0]         count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_result_kind,
  output logic [7:0]                         out_name_byte,
  output logic                               out_sni_found,
  output logic [15:0]                        out_name_length,
  output logic                               out_last_of_run
);

  tse_pkg::entry_t                  mem_r [tse_pkg::QDEPTH];
  logic [tse_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [tse_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [tse_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             sent_name_r, sent_name_nxt;
  tse_pkg::entry_t                  head;
  logic                             show_name;
  logic                             pop_part;
  logic                             pop_entry;

  assign count     = cnt_r;
  assign out_valid = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign show_name = head.has_name && !sent_name_r;
  assign pop_part  = out_valid && !out_stall;
  assign pop_entry = pop_part && (!show_name || !head.has_verdict);

  assign out_result_kind = !show_name;
  assign out_name_byte   = show_name ? head.name_byte : 8'd0;
  assign out_sni_found   = show_name ? 1'b0 : head.found;
  assign out_name_length = show_name ? 16'd0 : head.length;
  assign out_last_of_run = !show_name;

  always_comb begin
    cnt_nxt = cnt_r + {{(tse_pkg::QCNT_W-1){1'b0}}, push}
                    - {{(tse_pkg::QCNT_W-1){1'b0}}, pop_entry};
    sent_name_nxt = sent_name_r;
    if (pop_entry) begin
      sent_name_nxt = 1'b0;
    end else if (pop_part && show_name) begin
      sent_name_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      sent_name_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + {{(tse_pkg::QPTR_W-1){1'b0}}, 1'b1};
      end
      if (pop_entry) begin
        rd_ptr_r <= rd_ptr_r + {{(tse_pkg::QPTR_W-1){1'b0}}, 1'b1};
      end
      cnt_r       <= cnt_nxt;
      sent_name_r <= sent_name_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/tls_sni_extractor.sv @@
// ----------------------------------------------------------------------------
// tls_sni_extractor
// Streaming server-name extractor for a TLS ClientHello carried in TCP payload.
// ----------------------------------------------------------------------------
// One payload byte is taken per cycle while in_stall is low. Each byte is
// registered, parsed in the following cycle and its results enter a four-entry
// result queue, from which each name byte or verdict is presented in turn.
// The input stalls only when the result queue could not absorb the bytes in
// flight; a byte may yield two items (last name byte plus verdict), so a
// stalled or slow output side sets the sustained rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_sni_extractor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic [15:0] in_payload_length,
  input  wire logic        in_first_byte,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [7:0]       out_name_byte,
  output logic             out_sni_found,
  output logic [15:0]      out_name_length,
  output logic             out_last_of_run
);

  logic                         take;
  logic                         busy;
  logic                         push;
  tse_pkg::entry_t              entry;
  logic [tse_pkg::QCNT_W-1:0]   q_count;
  logic [tse_pkg::QCNT_W:0]     pending;

  assign pending  = {1'b0, q_count} + {{tse_pkg::QCNT_W{1'b0}}, busy};
  assign in_stall = (pending >= (tse_pkg::QCNT_W+1)'(tse_pkg::QDEPTH));
  assign take     = in_valid && !in_stall;

  tse_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .payload_byte   (in_payload_byte),
    .payload_length (in_payload_length),
    .first_byte     (in_first_byte),
    .final_byte     (in_final_byte),
    .busy           (busy),
    .push           (push),
    .entry          (entry)
  );

  tse_out_queue u_out_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .entry           (entry),
    .count           (q_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_name_byte   (out_name_byte),
    .out_sni_found   (out_sni_found),
    .out_name_length (out_name_length),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

@@ bench/tse_checker.sv @@
// ----------------------------------------------------------------------------
// tse_checker
// Watches both channels of the server-name extractor, predicts the name bytes
// and end-of-payload verdicts of every accepted payload byte, and compares
// each accepted result, field by field, with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tse_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic [15:0] in_payload_length,
  input  wire logic        in_first_byte,
  input  wire logic        in_final_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_result_kind,
  input  wire logic [7:0]  out_name_byte,
  input  wire logic        out_sni_found,
  input  wire logic [15:0] out_name_length,
  input  wire logic        out_last_of_run,
  output int               errors,
  output int               outstanding,
  output int               verdicts,
  output int               names_found,
  output int               name_bytes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic        found;
    logic [15:0] length;
    logic        last;
  } sni_result_t;

  sni_result_t result_q[$];
  int          results_seen;

  tse_pkg::phase_t phase;
  logic [16:0] byte_pos;
  logic [17:0] next_off;
  logic [17:0] ext_end;
  logic [7:0]  hi_byte;
  logic [15:0] ext_len;
  logic [15:0] name_left;
  logic [15:0] found_len;

  function automatic void clear_parser();
    phase     = tse_pkg::PH_IDLE;
    byte_pos  = '0;
    next_off  = '0;
    ext_end   = '0;
    hi_byte   = '0;
    ext_len   = '0;
    name_left = '0;
    found_len = '0;
  endfunction

  function automatic void goto_ext_header();
    if (32'(next_off) + 32'(tse_pkg::EXT_HDR_LEN) <= 32'(ext_end)) begin
      phase = tse_pkg::PH_TYPE_HI;
    end else begin
      phase = tse_pkg::PH_DONE;
    end
  endfunction

  function automatic bit parse_payload_byte(input logic [7:0] b, input int unsigned p,
                                            input int unsigned len);
    int unsigned v;
    bit          emit;
    emit = 1'b0;
    case (phase)
      tse_pkg::PH_HDR: begin
        if ((p == 32'(tse_pkg::POS_HDR_TYPE) && b != tse_pkg::REC_HANDSHAKE) ||
            (p == 32'(tse_pkg::POS_HDR_VER) && b != tse_pkg::VER_MAJOR_3 &&
             b != tse_pkg::VER_MAJOR_2) ||
            (p == 32'(tse_pkg::POS_HS_TYPE) && b != tse_pkg::HS_CLIENT_HELLO)) begin
          phase = tse_pkg::PH_DONE;
        end else if (p == 32'(tse_pkg::POS_HS_TYPE)) begin
          next_off = tse_pkg::SID_OFFSET;
          phase    = tse_pkg::PH_SID;
        end
      end
      tse_pkg::PH_SID: begin
        if (p == 32'(next_off)) begin
          next_off = 18'(p + 1 + 32'(b));
          phase    = tse_pkg::PH_CS_HI;
        end
      end
      tse_pkg::PH_CS_HI: begin
        if (p == 32'(next_off)) begin
          hi_byte = b;
          phase   = tse_pkg::PH_CS_LO;
        end
      end
      tse_pkg::PH_CS_LO: begin
        v        = 32'({hi_byte, b});
        next_off = 18'(p + 1 + v);
        phase    = tse_pkg::PH_COMP;
      end
      tse_pkg::PH_COMP: begin
        if (p == 32'(next_off)) begin
          next_off = 18'(p + 1 + 32'(b));
          phase    = tse_pkg::PH_EXT_HI;
        end
      end
      tse_pkg::PH_EXT_HI: begin
        if (p == 32'(next_off)) begin
          hi_byte = b;
          phase   = tse_pkg::PH_EXT_LO;
        end
      end
      tse_pkg::PH_EXT_LO: begin
        v        = 32'({hi_byte, b});
        ext_end  = 18'(p + 1 + v);
        next_off = 18'(p + 1);
        goto_ext_header();
      end
      tse_pkg::PH_TYPE_HI: begin
        if (p == 32'(next_off)) begin
          hi_byte = b;
          phase   = tse_pkg::PH_TYPE_LO;
        end
      end
      tse_pkg::PH_TYPE_LO: begin
        hi_byte = (hi_byte == tse_pkg::EXT_TYPE_SNI_HI &&
                   b == tse_pkg::EXT_TYPE_SNI_LO) ? 8'd1 : 8'd0;
        phase   = tse_pkg::PH_ELEN_HI;
      end
      tse_pkg::PH_ELEN_HI: begin
        ext_len = {b, 8'd0};
        phase   = tse_pkg::PH_ELEN_LO;
      end
      tse_pkg::PH_ELEN_LO: begin
        ext_len = ext_len | {8'd0, b};
        v       = p + 1;
        if (hi_byte == 8'd1 && v + 32'(ext_len) <= len &&
            ext_len >= tse_pkg::SNI_MIN_EXT_LEN) begin
          next_off = 18'(v + 32'(tse_pkg::SNI_LIST_HDR));
          phase    = tse_pkg::PH_NLEN_HI;
        end else begin
          next_off = 18'(v + 32'(ext_len));
          goto_ext_header();
        end
      end
      tse_pkg::PH_NLEN_HI: begin
        if (p == 32'(next_off)) begin
          hi_byte = b;
          phase   = tse_pkg::PH_NLEN_LO;
        end
      end
      tse_pkg::PH_NLEN_LO: begin
        v = 32'({hi_byte, b});
        if (v <= 32'(ext_len) - 32'(tse_pkg::SNI_MIN_EXT_LEN) && p + 1 + v <= len) begin
          if (v == 0) begin
            phase = tse_pkg::PH_DONE;
          end else begin
            ext_len   = 16'(v);
            name_left = 16'(v);
            phase     = tse_pkg::PH_NAME;
          end
        end else begin
          next_off = 18'(p - 4 + 32'(ext_len));
          goto_ext_header();
        end
      end
      tse_pkg::PH_NAME: begin
        name_left = name_left - 16'd1;
        if (name_left == 16'd0) begin
          found_len = ext_len;
          phase     = tse_pkg::PH_DONE;
        end
        emit = 1'b1;
      end
      default: begin
      end
    endcase
    return emit;
  endfunction

  function automatic void predict_payload_byte(input logic [7:0] b, input logic [15:0] len,
                                               input logic start, input logic closing);
    sni_result_t r;
    if (start) begin
      clear_parser();
      phase = tse_pkg::PH_HDR;
    end
    if (phase != tse_pkg::PH_IDLE) begin
      if (32'(byte_pos) < 32'(len)) begin
        if (parse_payload_byte(b, 32'(byte_pos), 32'(len))) begin
          r = '{1'b0, b, 1'b0, 16'd0, 1'b0};
          result_q.insert(result_q.size(), r);
        end
      end
      if (byte_pos != tse_pkg::POS_MAX) begin
        byte_pos = byte_pos + 17'd1;
      end
    end
    if (closing) begin
      r = '{1'b1, 8'd0, found_len != 16'd0, found_len, 1'b1};
      result_q.insert(result_q.size(), r);
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (errors < 50) begin
      $display("ERROR result %0d, %s: expected %0h, got %0h", results_seen, what, want, got);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    sni_result_t want;
    if (!rst_n) begin
      clear_parser();
      result_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_payload_byte(in_payload_byte, in_payload_length, in_first_byte, in_final_byte);
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("predictions waiting", 1, 0);
        end else begin
          want = result_q.pop_front();
          if (out_result_kind !== want.kind)
            report_mismatch("result_kind", want.kind, out_result_kind);
          if (out_name_byte !== want.name_byte)
            report_mismatch("name_byte", want.name_byte, out_name_byte);
          if (out_sni_found !== want.found)
            report_mismatch("sni_found", want.found, out_sni_found);
          if (out_name_length !== want.length)
            report_mismatch("name_length", want.length, out_name_length);
          if (out_last_of_run !== want.last)
            report_mismatch("last_of_run", want.last, out_last_of_run);
          if (want.kind) begin
            verdicts++;
            if (want.found) names_found++;
          end else begin
            name_bytes++;
          end
        end
        results_seen++;
      end
    end
    outstanding = result_q.size();
  end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives TCP payloads through the TLS server-name extractor: stray bytes,
// directed ClientHello cases, then random hellos with random content, some
// corrupted, truncated, cut short or restarted, under random idling on both
// channels. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 900;

  typedef enum int {
    SNI_NORMAL,
    SNI_EMPTY,
    SNI_SHORT_EXT,
    SNI_NAME_PAST_EXT,
    SNI_ABSENT
  } sni_form_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_payload_byte = '0;
  logic [15:0] in_payload_length = '0;
  logic        in_first_byte = 1'b0;
  logic        in_final_byte = 1'b0;
  logic        out_stall = 1'b0;
  wire logic   in_stall;
  wire logic   out_valid;
  wire logic   out_result_kind;
  wire logic [7:0]  out_name_byte;
  wire logic   out_sni_found;
  wire logic [15:0] out_name_length;
  wire logic   out_last_of_run;

  int errors;
  int outstanding;
  int verdicts;
  int names_found;
  int name_bytes;

  logic [7:0] pkt[$];
  int         ext_len_at;
  int         name_at;
  int         tx_busy_pct;
  int         rx_busy_pct;
  int         items_sent;
  int         packets_sent;
  int         cycle_count;

  tls_sni_extractor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_payload_byte   (in_payload_byte),
    .in_payload_length (in_payload_length),
    .in_first_byte     (in_first_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_name_byte     (out_name_byte),
    .out_sni_found     (out_sni_found),
    .out_name_length   (out_name_length),
    .out_last_of_run   (out_last_of_run)
  );

  tse_checker sni_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_payload_byte   (in_payload_byte),
    .in_payload_length (in_payload_length),
    .in_first_byte     (in_first_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_name_byte     (out_name_byte),
    .out_sni_found     (out_sni_found),
    .out_name_length   (out_name_length),
    .out_last_of_run   (out_last_of_run),
    .errors            (errors),
    .outstanding       (outstanding),
    .verdicts          (verdicts),
    .names_found       (names_found),
    .name_bytes        (name_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_busy();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 50;
      default: return 100;
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] v);
    pkt.insert(pkt.size(), v);
  endfunction

  function automatic void push16(input int v);
    add_byte(8'(v >> 8));
    add_byte(8'(v));
  endfunction

  function automatic void push_random(input int count);
    repeat (count) add_byte(8'($urandom));
  endfunction

  function automatic void shorten_extensions(input int by);
    int total;
    total = int'({pkt[ext_len_at], pkt[ext_len_at + 1]});
    if (total >= by) begin
      total = total - by;
      pkt[ext_len_at]     = 8'(total >> 8);
      pkt[ext_len_at + 1] = 8'(total);
    end
  endfunction

  function automatic void build_hello(input int sid_n, input int suite_n, input int comp_n,
                                      input int other_n, input sni_form_t form,
                                      input int name_n);
    int sni_slot;
    int ext_start;
    int body;
    int nlen;
    int slack;
    int total;
    pkt.delete();
    name_at = -1;
    add_byte(tse_pkg::REC_HANDSHAKE);
    add_byte($urandom_range(0, 1) ? tse_pkg::VER_MAJOR_3 : tse_pkg::VER_MAJOR_2);
    push_random(3);
    add_byte(tse_pkg::HS_CLIENT_HELLO);
    while (pkt.size() < int'(tse_pkg::SID_OFFSET)) add_byte(8'($urandom));
    add_byte(8'(sid_n));
    push_random(sid_n);
    push16(suite_n);
    push_random(suite_n);
    add_byte(8'(comp_n));
    push_random(comp_n);
    ext_len_at = pkt.size();
    push16(0);
    ext_start = pkt.size();
    sni_slot = $urandom_range(0, other_n);
    for (int i = 0; i <= other_n; i++) begin
      if (i == sni_slot && form != SNI_ABSENT) begin
        add_byte(tse_pkg::EXT_TYPE_SNI_HI);
        add_byte(tse_pkg::EXT_TYPE_SNI_LO);
        if (form == SNI_SHORT_EXT) begin
          body = $urandom_range(0, int'(tse_pkg::SNI_MIN_EXT_LEN) - 1);
          push16(body);
          push_random(body);
        end else begin
          slack = (form != SNI_NAME_PAST_EXT && $urandom_range(0, 3) == 0) ?
                  $urandom_range(1, 2) : 0;
          nlen = (form == SNI_NAME_PAST_EXT) ? name_n + $urandom_range(1, 3) : name_n;
          push16(int'(tse_pkg::SNI_MIN_EXT_LEN) + name_n + slack);
          push16(nlen + int'(tse_pkg::SNI_LIST_HDR));
          push_random(1);
          push16(nlen);
          if (form == SNI_NORMAL) name_at = pkt.size();
          push_random(name_n + slack);
        end
      end
      if (i < other_n) begin
        push16($urandom_range(0, 3) == 0 ? $urandom_range(1, 255) : $urandom_range(256, 65535));
        body = $urandom_range(0, 6);
        push16(body);
        push_random(body);
      end
    end
    total = pkt.size() - ext_start;
    pkt[ext_len_at]     = 8'(total >> 8);
    pkt[ext_len_at + 1] = 8'(total);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic [15:0] len, input logic start,
                           input logic stop);
    int gap;
    gap = ($urandom_range(0, 99) < tx_busy_pct) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_payload_byte   <= b;
    in_payload_length <= len;
    in_first_byte     <= start;
    in_final_byte     <= stop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet(input int count, input int len, input logic closed);
    for (int i = 0; i < count; i++) begin
      send_item(pkt[i], 16'(len), i == 0, closed && i == count - 1);
    end
    items_sent += count;
    packets_sent++;
  endtask

  task automatic send_noise(input int count, input logic closed);
    for (int i = 0; i < count; i++) begin
      send_item(8'($urandom), 16'($urandom), 1'b0, closed && i == count - 1);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 99) < rx_busy_pct) ? $urandom_range(1, 16) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int roll;
    int plen;
    int count;
    int sel;
    int stop_at;
    logic closed;
    tx_busy_pct = 0;
    rx_busy_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // stray bytes before any first byte, then a lone verdict
    send_noise(3, 1'b0);
    send_noise(1, 1'b1);

    build_hello(0, 2, 1, 0, SNI_NORMAL, 8);
    send_packet(1, 1, 1'b1);

    pkt[tse_pkg::POS_HDR_TYPE] = 8'h17;
    send_packet(pkt.size(), pkt.size(), 1'b1);
    build_hello(0, 2, 1, 0, SNI_NORMAL, 8);
    pkt[tse_pkg::POS_HDR_VER] = 8'h04;
    send_packet(pkt.size(), pkt.size(), 1'b1);
    build_hello(0, 2, 1, 0, SNI_NORMAL, 8);
    pkt[tse_pkg::POS_HS_TYPE] = 8'h02;
    send_packet(pkt.size(), pkt.size(), 1'b1);

    build_hello(0, 2, 1, 0, SNI_NORMAL, 1);
    send_packet(pkt.size(), pkt.size(), 1'b1);

    tx_busy_pct = 100;
    rx_busy_pct = 100;
    build_hello(32, 12, 3, 3, SNI_NORMAL, 32);
    send_packet(pkt.size(), 16'hFFFF, 1'b1);

    tx_busy_pct = 50;
    rx_busy_pct = 10;
    build_hello(1, 2, 1, 1, SNI_EMPTY, 0);
    send_packet(pkt.size(), pkt.size(), 1'b1);
    build_hello(0, 2, 1, 2, SNI_SHORT_EXT, 0);
    send_packet(pkt.size(), pkt.size(), 1'b1);
    build_hello(0, 4, 1, 1, SNI_NAME_PAST_EXT, 6);
    send_packet(pkt.size(), pkt.size(), 1'b1);
    build_hello(0, 2, 1, 2, SNI_ABSENT, 0);
    send_packet(pkt.size(), pkt.size(), 1'b1);
    build_hello(0, 2, 1, 2, SNI_NORMAL, 5);
    shorten_extensions(1);
    send_packet(pkt.size(), pkt.size(), 1'b1);

    // extension no longer fits the declared payload length
    build_hello(0, 2, 1, 0, SNI_NORMAL, 10);
    send_packet(pkt.size(), pkt.size() - 3, 1'b1);

    // payload ends inside the name
    build_hello(0, 2, 1, 0, SNI_NORMAL, 10);
    send_packet(name_at + 4, pkt.size(), 1'b1);

    // restart in the middle of a payload
    build_hello(0, 2, 1, 0, SNI_NORMAL, 10);
    send_packet(name_at + 2, pkt.size(), 1'b0);
    build_hello(2, 6, 2, 1, SNI_NORMAL, 12);
    send_packet(pkt.size(), pkt.size(), 1'b1);

    wait_for_drain();

    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      tx_busy_pct = pick_busy();
      rx_busy_pct = pick_busy();
      sel = $urandom_range(0, 99);
      build_hello($urandom_range(0, 3) == 0 ? $urandom_range(1, 32) : 0,
                  $urandom_range(0, 12), $urandom_range(0, 3), $urandom_range(0, 3),
                  sel < 60 ? SNI_NORMAL : sel < 70 ? SNI_EMPTY : sel < 80 ? SNI_SHORT_EXT :
                  sel < 90 ? SNI_NAME_PAST_EXT : SNI_ABSENT,
                  sel >= 60 && sel < 70 ? 0 : $urandom_range(1, 32));
      roll   = $urandom_range(0, 99);
      plen   = pkt.size();
      count  = pkt.size();
      closed = 1'b1;
      if (roll < 70) begin
        if ($urandom_range(0, 9) == 0) plen = plen + $urandom_range(1, 2000);
      end else if (roll < 74) begin
        case ($urandom_range(0, 2))
          0:       sel = int'(tse_pkg::POS_HDR_TYPE);
          1:       sel = int'(tse_pkg::POS_HDR_VER);
          default: sel = int'(tse_pkg::POS_HS_TYPE);
        endcase
        pkt[sel] = pkt[sel] ^ 8'($urandom_range(4, 255));
      end else if (roll < 79) begin
        shorten_extensions($urandom_range(1, 3));
      end else if (roll < 84) begin
        plen = $urandom_range(0, pkt.size() - 1);
      end else if (roll < 89) begin
        count = (name_at >= 0) ? $urandom_range(name_at + 1, pkt.size() - 1) :
                $urandom_range(1, pkt.size() - 1);
      end else if (roll < 94) begin
        closed = 1'b0;
        count  = $urandom_range(1, pkt.size() - 1);
      end else begin
        send_noise($urandom_range(1, 20), 1'($urandom_range(0, 1)));
        continue;
      end
      send_packet(count, plen, closed);
      if ($urandom_range(0, 19) == 0) wait_for_drain();
    end

    rx_busy_pct = 0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d payload bytes in %0d packets, with stray bytes between them.",
             items_sent, packets_sent);
    $display("Checked %0d name bytes and %0d verdicts, %0d of them reporting a name.",
             name_bytes, verdicts, names_found);
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
